FILE: hw/rtl/wcir_pkg.sv
package wcir_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 11;
  localparam int WORD_W      = 16;
  localparam int PHASE_W     = 17;
  localparam int PROD_W      = PHASE_W + LEN_W;
  localparam int ACC_W       = 58;
  localparam int MPL_W       = 17;
  localparam int Q_W         = 25;
  localparam int DIVN_W      = 27;
  localparam int CNT_W       = 5;
  localparam int MUL_STEPS   = 17;

  // divide by three as a multiply by ceil(2^28 / 3), exact below 2^27
  localparam int                RECIP_W  = 54;
  localparam int                RECIP_SH = 28;
  localparam logic [DIVN_W-1:0] RECIP3   = 27'd89478486;

  localparam logic [WORD_W-1:0] WORD_ONE  = 16'd32768;
  localparam logic signed [15:0] GATE_RISE = 16'sd6554;
  localparam logic signed [15:0] GATE_FALL = 16'sd327;

  // stream widths
  localparam int S_DATA_W = 96;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 40;

  // register indexes
  localparam logic [1:0] REG_PHASE_RANGE  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_RANGE = 2'd1;
  localparam logic [1:0] REG_BOUNDARY     = 2'd2;
  localparam logic [1:0] REG_TABLE_LENGTH = 2'd3;

  // span and boundary codes
  localparam logic [1:0] SPAN_WIDE   = 2'd0;
  localparam logic [1:0] SPAN_NARROW = 2'd1;
  localparam logic [1:0] BND_CLAMP   = 2'd0;
  localparam logic [1:0] BND_MIRROR  = 2'd1;

  typedef struct packed {
    logic [1:0]       phase_range;
    logic [1:0]       output_range;
    logic [1:0]       boundary_mode;
    logic [LEN_W-1:0] table_length;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIRECT, OP_GATE, OP_RECORD, OP_LOCATE, OP_INDEX,
    OP_READ_A, OP_READ_B, OP_READ_C, OP_READ_D, OP_LAST_D, OP_COEF,
    OP_MUL1, OP_MUL2, OP_MUL3, OP_MSTEP, OP_DIV, OP_DSTEP, OP_FINAL
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_DIRECT, ST_GATE, ST_RECORD, ST_LOCATE, ST_INDEX,
    ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_D, ST_RD_LAST, ST_COEF,
    ST_M1, ST_M1_RUN, ST_M2, ST_M2_RUN, ST_M3, ST_M3_RUN,
    ST_DIV, ST_DIV_RUN, ST_FINAL, ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
    logic   push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic action;
    logic apply_record;
    logic unit_last;
  } dp_status_t;

  // length in use, clamped to 2..TABLE_DEPTH
  function automatic logic [LEN_W-1:0] len_use(input logic [LEN_W-1:0] tl);
    logic [LEN_W-1:0] l;
    begin
      l = tl;
      if (tl < LEN_W'(2)) l = LEN_W'(2);
      if (tl > LEN_W'(TABLE_DEPTH)) l = LEN_W'(TABLE_DEPTH);
      return l;
    end
  endfunction

  // position voltage to q16 fraction 0..65536
  function automatic logic [PHASE_W-1:0] phase_q16(input logic signed [15:0] x,
                                                   input logic [1:0] rng);
    logic signed [17:0] t;
    begin
      t = 18'(x);
      if (rng == SPAN_WIDE) begin
        t = t + 18'sd32768;
        return t[16:0];
      end else if (rng == SPAN_NARROW) begin
        t = t + 18'sd16384;
        if (t < 18'sd0) t = 18'sd0;
        if (t > 18'sd32768) t = 18'sd32768;
        return {t[15:0], 1'b0};
      end else begin
        if (t < 18'sd0) t = 18'sd0;
        return {t[15:0], 1'b0};
      end
    end
  endfunction

  // record voltage to table word
  function automatic logic [WORD_W-1:0] rec_word(input logic signed [15:0] x,
                                                 input logic [1:0] rng);
    logic signed [17:0] t;
    begin
      t = 18'(x);
      if (rng == SPAN_WIDE) begin
        t = t + 18'sd32768;
        return t[16:1];
      end else if (rng == SPAN_NARROW) begin
        t = t + 18'sd16384;
        if (t < 18'sd0) t = 18'sd0;
        if (t > 18'sd32768) t = 18'sd32768;
        return t[15:0];
      end else begin
        if (t < 18'sd0) t = 18'sd0;
        return t[15:0];
      end
    end
  endfunction

  // table word to saturated output voltage
  function automatic logic signed [15:0] to_volts(input logic signed [27:0] y,
                                                  input logic [1:0] rng);
    logic signed [29:0] v;
    begin
      v = 30'(y);
      if (rng == SPAN_WIDE) v = (v <<< 1) - 30'sd32768;
      else if (rng == SPAN_NARROW) v = v - 30'sd16384;
      if (v > 30'sd32767) v = 30'sd32767;
      if (v < -30'sd32768) v = -30'sd32768;
      return v[15:0];
    end
  endfunction

endpackage

FILE: hw/rtl/wcir_ctrl.sv
module wcir_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_free,
  input  wcir_pkg::dp_status_t status,
  output wcir_pkg::ctrl_cmd_t  cmd
);
  import wcir_pkg::*;

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.in_ready = 1'b0;
    cmd.push     = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.action) state_next = ST_DIRECT;
        else if (status.apply_record) state_next = ST_GATE;
        else state_next = ST_LOCATE;
      end
      ST_DIRECT: begin cmd.op = OP_DIRECT; state_next = ST_OUT; end
      ST_GATE: begin cmd.op = OP_GATE; state_next = ST_RECORD; end
      ST_RECORD: begin cmd.op = OP_RECORD; state_next = ST_LOCATE; end
      ST_LOCATE: begin cmd.op = OP_LOCATE; state_next = ST_INDEX; end
      ST_INDEX: begin cmd.op = OP_INDEX; state_next = ST_RD_A; end
      ST_RD_A: begin cmd.op = OP_READ_A; state_next = ST_RD_B; end
      ST_RD_B: begin cmd.op = OP_READ_B; state_next = ST_RD_C; end
      ST_RD_C: begin cmd.op = OP_READ_C; state_next = ST_RD_D; end
      ST_RD_D: begin cmd.op = OP_READ_D; state_next = ST_RD_LAST; end
      ST_RD_LAST: begin cmd.op = OP_LAST_D; state_next = ST_COEF; end
      ST_COEF: begin cmd.op = OP_COEF; state_next = ST_M1; end
      ST_M1: begin cmd.op = OP_MUL1; state_next = ST_M1_RUN; end
      ST_M1_RUN: begin
        cmd.op = OP_MSTEP;
        if (status.unit_last) state_next = ST_M2;
      end
      ST_M2: begin cmd.op = OP_MUL2; state_next = ST_M2_RUN; end
      ST_M2_RUN: begin
        cmd.op = OP_MSTEP;
        if (status.unit_last) state_next = ST_M3;
      end
      ST_M3: begin cmd.op = OP_MUL3; state_next = ST_M3_RUN; end
      ST_M3_RUN: begin
        cmd.op = OP_MSTEP;
        if (status.unit_last) state_next = ST_DIV;
      end
      ST_DIV: begin cmd.op = OP_DIV; state_next = ST_DIV_RUN; end
      ST_DIV_RUN: begin cmd.op = OP_DSTEP; state_next = ST_FINAL; end
      ST_FINAL: begin cmd.op = OP_FINAL; state_next = ST_OUT; end
      ST_OUT: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/wcir_dp.sv
module wcir_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  wcir_pkg::cfg_t                    cfg,
  input  wcir_pkg::dp_op_t                  op,
  input  logic [wcir_pkg::S_DATA_W-1:0]     in_data,
  input  logic [wcir_pkg::S_USER_W-1:0]     in_user,
  output wcir_pkg::dp_status_t              status,
  output logic signed [15:0]                res_step,
  output logic signed [15:0]                res_interp,
  output logic                              res_rec
);
  import wcir_pkg::*;

  // table store
  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  // captured request
  logic               act, apply;
  logic [ADDR_W-1:0]  wi;
  logic [WORD_W-1:0]  wv;
  logic signed [15:0] gate_v;
  logic [WORD_W-1:0]  rec_w;
  logic [PHASE_W-1:0] p_rec, p_play;
  logic               gate_high;

  // locate and neighbours
  logic [LEN_W-1:0]   len;
  logic [PROD_W-1:0]  prod;
  logic [11:0]        i_raw, lim;
  logic [ADDR_W-1:0]  i_cl;
  logic [PROD_W-1:0]  g_full;
  logic [MPL_W-1:0]   g;
  logic [11:0]        i12, n_a, n_c, n_d;
  logic [ADDR_W-1:0]  ia, ib, ic, id;

  // words and arithmetic unit
  logic [WORD_W-1:0]        wa, wb, wc, wd;
  logic signed [19:0]       cx, cy, cb;
  logic signed [ACC_W-1:0]  acc, mcand, cb6;
  logic [MPL_W-1:0]         mpl;
  logic [CNT_W-1:0]         cnt;
  logic [DIVN_W-1:0]        divn, quot;
  logic signed [Q_W-1:0]    qv;
  logic signed [27:0]       qd, yv;

  assign len = len_use(cfg.table_length);

  // index and fraction from the registered product
  assign i_raw  = prod[PROD_W-1:16];
  assign lim    = 12'(len) - 12'd1;
  assign i_cl   = (i_raw > lim) ? lim[ADDR_W-1:0] : i_raw[ADDR_W-1:0];
  assign g_full = prod - {2'b0, i_cl, 16'b0};
  assign g      = g_full[MPL_W-1:0];

  // neighbour indices under the boundary rule
  always_comb begin
    i12 = 12'(i_cl);
    n_c = (i12 + 12'd1 < 12'(len)) ? i12 + 12'd1 : lim;
    if (cfg.boundary_mode == BND_CLAMP) begin
      n_a = (i12 == 12'd0) ? 12'd0 : i12 - 12'd1;
      n_d = (i12 + 12'd2 < 12'(len)) ? i12 + 12'd2 : lim;
    end else if (cfg.boundary_mode == BND_MIRROR) begin
      n_a = (i12 == 12'd0) ? 12'd1 : i12 - 12'd1;
      n_d = (i12 + 12'd2 < 12'(len)) ? i12 + 12'd2
                                    : (12'(len) << 1) - (i12 + 12'd3);
    end else begin
      n_a = (i12 == 12'd0) ? lim : i12 - 12'd1;
      n_c = (i12 + 12'd1 < 12'(len)) ? i12 + 12'd1 : 12'd0;
      n_d = (i12 + 12'd2 < 12'(len)) ? i12 + 12'd2 : i12 + 12'd2 - 12'(len);
    end
  end

  // memory port selection
  always_comb begin
    mem_addr  = ia;
    mem_we    = 1'b0;
    mem_wdata = rec_w;
    case (op)
      OP_DIRECT: begin
        mem_addr  = wi;
        mem_we    = 1'b1;
        mem_wdata = (wv > WORD_ONE) ? WORD_ONE : wv;
      end
      OP_RECORD: begin
        mem_addr = i_cl;
        mem_we   = gate_high;
      end
      OP_READ_B: mem_addr = ib;
      OP_READ_C: mem_addr = ic;
      OP_READ_D: mem_addr = id;
      default: mem_addr = ia;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q <= mem[mem_addr];
  end

  // final values
  assign cb6 = (ACC_W'(cb) <<< 2) + (ACC_W'(cb) <<< 1);
  assign qv  = acc[ACC_W-1:33];
  assign qd  = $signed({1'b0, quot}) - 28'sd16777216;
  assign yv  = qd + $signed(28'(wb));

  // gate state
  always_ff @(posedge clk) begin
    if (rst) gate_high <= 1'b0;
    else if (op == OP_GATE) begin
      if (gate_high && gate_v <= GATE_FALL) gate_high <= 1'b0;
      else if (!gate_high && gate_v >= GATE_RISE) gate_high <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        act    <= in_user[0];
        apply  <= in_user[1];
        wi     <= in_data[9:0];
        wv     <= in_data[25:10];
        gate_v <= in_data[41:26];
        p_rec  <= phase_q16(in_data[57:42], cfg.phase_range);
        rec_w  <= rec_word(in_data[73:58], cfg.output_range);
        p_play <= phase_q16(in_data[89:74], cfg.phase_range);
      end
      OP_DIRECT: begin
        res_step   <= '0;
        res_interp <= '0;
        res_rec    <= gate_high;
      end
      OP_GATE:   prod <= PROD_W'(p_rec) * PROD_W'(len);
      OP_LOCATE: prod <= PROD_W'(p_play) * PROD_W'(len);
      OP_INDEX: begin
        ia <= n_a[ADDR_W-1:0];
        ib <= i_cl;
        ic <= n_c[ADDR_W-1:0];
        id <= n_d[ADDR_W-1:0];
      end
      OP_READ_B: wa <= mem_q;
      OP_READ_C: wb <= mem_q;
      OP_READ_D: wc <= mem_q;
      OP_LAST_D: wd <= mem_q;
      OP_COEF: begin
        cx <= $signed(20'(wd)) - $signed(20'(wa))
              - 20'sd3 * ($signed(20'(wc)) - $signed(20'(wb)));
        cy <= $signed(20'(wd)) + ($signed(20'(wa)) <<< 1) - 20'sd3 * $signed(20'(wb));
        cb <= $signed(20'(wc)) - $signed(20'(wb));
      end
      // P = X*g + Y*2^16
      OP_MUL1: begin
        mcand <= ACC_W'(cx);
        mpl   <= g;
        acc   <= ACC_W'(cy) <<< 16;
        cnt   <= CNT_W'(MUL_STEPS);
      end
      // R = 6*2^32*(c-b) - P*h
      OP_MUL2: begin
        mcand <= -acc;
        mpl   <= MPL_W'(18'd65536 - 18'(g));
        acc   <= cb6 <<< 32;
        cnt   <= CNT_W'(MUL_STEPS);
      end
      // T = floor(R/2^16)*g + 3*2^32
      OP_MUL3: begin
        mcand <= acc >>> 16;
        mpl   <= g;
        acc   <= ACC_W'(3) <<< 32;
        cnt   <= CNT_W'(MUL_STEPS);
      end
      OP_MSTEP: begin
        if (mpl[0]) acc <= acc + mcand;
        mcand <= mcand <<< 1;
        mpl   <= mpl >> 1;
        cnt   <= cnt - CNT_W'(1);
      end
      // floor(T/2^33) offset to stay positive, then divided by three
      OP_DIV: divn <= DIVN_W'(qv) + DIVN_W'(50331648);
      // divide by three through the reciprocal
      OP_DSTEP: quot <= DIVN_W'((RECIP_W'(divn) * RECIP_W'(RECIP3)) >> RECIP_SH);
      OP_FINAL: begin
        res_step   <= to_volts($signed(28'(wb)), cfg.output_range);
        res_interp <= to_volts(yv, cfg.output_range);
        res_rec    <= gate_high;
      end
      default: ;
    endcase
  end

  assign status.action       = act;
  assign status.apply_record = apply;
  assign status.unit_last    = (cnt == CNT_W'(1));

endmodule

FILE: hw/rtl/wavetable_cubic_interp_recorder_unit.sv
// channel  | direction | handshake              | payload
// s        | in        | s_tvalid / s_tready    | s_tdata, s_tuser
// m        | out       | m_tvalid / m_tready    | m_tdata
// cfg      | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// a direct-write request passes from accept through one table write to the output;
// a play request locates, reads four neighbours and computes, after a gate step and
// a table write when it records; three 17-step shift-add multiplies dominate, the
// divide by three is one reciprocal multiply, the four table reads share one port
// reset is synchronous; the table itself is not cleared
// one request is in work at a time; a result waiting in the output register
// does not block the next accept, only the hand-over of the following result
module wavetable_cubic_interp_recorder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // write_index, write_value, rec_gate_volts, rec_phase_volts,
  // rec_signal_volts, play_phase_volts, zero pad
  input  logic [wcir_pkg::S_DATA_W-1:0] s_tdata,
  // action, apply_record
  input  logic [wcir_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // step_out, interp_out, recording, zero pad
  output logic [wcir_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [10:0]                   cfg_data
);
  import wcir_pkg::*;

  cfg_t               cfg;
  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               out_free;
  logic signed [15:0] res_step, res_interp;
  logic               res_rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_range   <= 2'd2;
      cfg.output_range  <= 2'd0;
      cfg.boundary_mode <= 2'd2;
      cfg.table_length  <= 11'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_RANGE:  cfg.phase_range   <= cfg_data[1:0];
        REG_OUTPUT_RANGE: cfg.output_range  <= cfg_data[1:0];
        REG_BOUNDARY:     cfg.boundary_mode <= cfg_data[1:0];
        REG_TABLE_LENGTH: cfg.table_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  wcir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  wcir_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .op         (cmd.op),
    .in_data    (s_tdata),
    .in_user    (s_tuser),
    .status     (status),
    .res_step   (res_step),
    .res_interp (res_interp),
    .res_rec    (res_rec)
  );

  assign s_tready = cmd.in_ready;
  assign out_free = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.push) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) m_tdata <= {7'b0, res_rec, res_interp, res_step};
  end

endmodule

FILE: hw/rtl/wcir_chk.sv
module wcir_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one request in work at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // a result never appears in the cycle after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result without processing time");

endmodule

bind wavetable_cubic_interp_recorder_unit wcir_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/tb.sv
module tb;
  import wcir_pkg::*;

  // one expected result
  typedef struct {
    logic signed [15:0] step_out;
    logic signed [15:0] interp_out;
    logic               recording;
  } wave_result_t;

  // predictor of the wavetable unit and store of pending results
  class wave_scoreboard;
    logic [15:0]      table_word [TABLE_DEPTH];
    logic             gate_high;
    logic [1:0]       phase_rng;
    logic [1:0]       out_rng;
    logic [1:0]       bnd;
    logic [10:0]      tab_len;
    wave_result_t     pending_results [$];
    int               fail_count;

    function void reset_state();
      gate_high = 1'b0;
      phase_rng = 2'd2;
      out_rng   = 2'd0;
      bnd       = 2'd2;
      tab_len   = 11'd10;
      fail_count = 0;
      pending_results.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        REG_PHASE_RANGE:  phase_rng = val[1:0];
        REG_OUTPUT_RANGE: out_rng   = val[1:0];
        REG_BOUNDARY:     bnd       = val[1:0];
        default:          tab_len   = val;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint position_q16(longint x);
      if (phase_rng == SPAN_WIDE) return x + 32768;
      if (phase_rng == SPAN_NARROW) return 2 * clip(x + 16384, 0, 32768);
      return 2 * clip(x, 0, 32767);
    endfunction

    function longint volts_of(longint y);
      longint v;
      if (out_rng == SPAN_WIDE) v = 2 * y - 32768;
      else if (out_rng == SPAN_NARROW) v = y - 16384;
      else v = y;
      return clip(v, -32768, 32767);
    endfunction

    // index and fraction for a q16 position
    function void find_slot(longint p, longint len, output longint idx, output longint g);
      longint prod;
      prod = p * len;
      idx = prod >>> 16;
      if (idx > len - 1) idx = len - 1;
      g = prod - (idx <<< 16);
    endfunction

    // accepted request: update the state and queue its result
    function void note_request(logic [95:0] data, logic [1:0] user);
      wave_result_t r;
      longint len, idx, g, ri, rg, w, x;
      longint ia, ib, ic, id, a, b, c, d, pp, rr, s, y;
      longint den;
      logic [15:0] wv;
      den = 64'd6 * 64'd4294967296;
      len = tab_len < 2 ? 2 : (tab_len > TABLE_DEPTH ? TABLE_DEPTH : tab_len);
      if (user[0]) begin
        wv = data[25:10];
        table_word[data[9:0]] = wv > WORD_ONE ? WORD_ONE : wv;
        r.step_out = '0;
        r.interp_out = '0;
        r.recording = gate_high;
        pending_results.insert(pending_results.size(), r);
        return;
      end
      // gate schmitt trigger and recording
      if (user[1]) begin
        x = longint'($signed(data[41:26]));
        if (gate_high) begin
          if (x <= 327) gate_high = 1'b0;
        end else if (x >= 6554) begin
          gate_high = 1'b1;
        end
        if (gate_high) begin
          find_slot(position_q16(longint'($signed(data[57:42]))), len, ri, rg);
          x = longint'($signed(data[73:58]));
          if (out_rng == SPAN_WIDE) w = (x + 32768) / 2;
          else if (out_rng == SPAN_NARROW) w = clip(x + 16384, 0, 32768);
          else w = clip(x, 0, 32768);
          table_word[ri] = w[15:0];
        end
      end
      find_slot(position_q16(longint'($signed(data[89:74]))), len, idx, g);
      // neighbour indexes under the edge rule
      ib = idx;
      if (bnd == BND_CLAMP) begin
        ia = idx == 0 ? 0 : idx - 1;
        ic = idx + 1 < len ? idx + 1 : len - 1;
        id = idx + 2 < len ? idx + 2 : len - 1;
      end else if (bnd == BND_MIRROR) begin
        ia = idx < 1 ? 1 : idx - 1;
        ic = idx + 1 < len ? idx + 1 : len - 1;
        id = idx + 2 < len ? idx + 2 : 2 * len - (idx + 3);
      end else begin
        ia = (idx + len - 1) % len;
        ic = (idx + 1) % len;
        id = (idx + 2) % len;
      end
      a = table_word[ia];
      b = table_word[ib];
      c = table_word[ic];
      d = table_word[id];
      pp = (d - a - 3 * (c - b)) * g + (d + 2 * a - 3 * b) * 65536;
      rr = (c - b) * den - pp * (65536 - g);
      s = floor_div(rr, 65536);
      y = b + floor_div(s * g + den / 2, den);
      r.step_out = 16'(volts_of(b));
      r.interp_out = 16'(volts_of(y));
      r.recording = gate_high;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(logic [39:0] data);
      wave_result_t e;
      if (pending_results.size() == 0) begin
        $error("result 0x%010h with no request pending", data);
        fail_count++;
        return;
      end
      e = pending_results.pop_front();
      if (data[15:0] !== e.step_out) begin
        $error("step_out expected %0d got %0d", e.step_out, $signed(data[15:0]));
        fail_count++;
      end
      if (data[31:16] !== e.interp_out) begin
        $error("interp_out expected %0d got %0d", e.interp_out, $signed(data[31:16]));
        fail_count++;
      end
      if (data[32] !== e.recording) begin
        $error("recording expected %0d got %0d", e.recording, data[32]);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [95:0]        s_tdata;
  logic [1:0]         s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [39:0]        m_tdata;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [10:0]        cfg_data;

  wave_scoreboard     wave_sb;
  int                 idle_mode;
  bit                 hold_off_req;

  wavetable_cubic_interp_recorder_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

  // request and result monitor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) wave_sb.note_request(s_tdata, s_tuser);
    if (!rst && m_tvalid && m_tready) wave_sb.check_result(m_tdata);
  end

  // result side: stalls and the long hold-off
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_mode == 2) begin
        m_tready <= $urandom_range(99) >= 63;
      end else if (idle_mode == 3) begin
        m_tready <= $urandom_range(99) >= 15;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one request and wait for its accept, then maybe pause
  task automatic send_request(logic act, logic [9:0] wi, logic [15:0] wv, logic ar,
                              logic [15:0] gv, logic [15:0] rp, logic [15:0] rs,
                              logic [15:0] pp);
    int gap;
    s_tdata  <= {6'd0, pp, rs, rp, gv, wv, wi};
    s_tuser  <= {ar, act};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = 0;
    if (idle_mode == 1 && $urandom_range(99) < 63) gap = 1;
    if (idle_mode == 3 && $urandom_range(99) < 15) gap = 1;
    if (gap) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, $urandom_range(3) == 0 ? 120 : 4)) @(posedge clk);
    end
  endtask

  task automatic play(logic ar, logic [15:0] gv, logic [15:0] rp, logic [15:0] rs,
                      logic [15:0] pp);
    send_request(1'b0, 10'($urandom), 16'($urandom), ar, gv, rp, rs, pp);
  endtask

  // pick a voltage, leaning on the extremes and gate thresholds
  function automatic logic [15:0] pick_volts();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(6554 + $urandom_range(2) - 1);
      3: return 16'(327 + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (wave_sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    wave_sb.write_reg(idx, val);
  endtask

  // phase settings: phase span, output span, edge rule, length
  logic [1:0]  ph_prange [8] = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0};
  logic [1:0]  ph_orange [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd0};
  logic [1:0]  ph_bnd    [8] = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1};
  logic [10:0] ph_len    [8] = '{11'd10, 11'd2, 11'd3, 11'd1024, 11'd0, 11'd2047,
                                 11'd4, 11'd37};

  initial begin
    int n;
    wave_sb = new();
    wave_sb.reset_state();
    idle_mode = 0;
    hold_off_req = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table so no read hits an unwritten entry
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_request(1'b1, k[9:0], 16'($urandom_range(32768)), 1'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));

    // directed: extremes, gate thresholds, clamped write, top position
    send_request(1'b1, 10'd0, 16'hffff, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_request(1'b1, 10'd1023, 16'd32768, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    play(1'b0, 16'h7fff, 16'h0, 16'h0, 16'h7fff);
    play(1'b0, 16'h0, 16'h0, 16'h0, 16'h8000);
    play(1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    play(1'b1, 16'd6553, 16'h7fff, 16'h7fff, 16'h7fff);
    play(1'b1, 16'd6554, 16'h7fff, 16'h7fff, 16'h7fff);
    play(1'b0, 16'h0, 16'h0, 16'h0, 16'h7000);
    play(1'b1, 16'd328, 16'h0, 16'h8000, 16'h0);
    play(1'b1, 16'd327, 16'h0, 16'h0, 16'h0);
    play(1'b1, 16'h7fff, 16'h8000, 16'h8000, 16'h4000);
    play(1'b1, 16'h8000, 16'h4000, 16'h1234, 16'h4000);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PHASE_RANGE, ph_prange[ph]);
      write_reg(REG_OUTPUT_RANGE, ph_orange[ph]);
      write_reg(REG_BOUNDARY, ph_bnd[ph]);
      write_reg(REG_TABLE_LENGTH, ph_len[ph]);
      cfg_we <= 1'b0;
      @(posedge clk);
      idle_mode = ph % 4;
      if (ph == 4) hold_off_req = 1'b1;
      n = 60;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0)
          send_request(1'b1, 10'($urandom_range(TABLE_DEPTH - 1)), $urandom_range(3) == 0 ?
                       16'($urandom) : 16'($urandom_range(32768)), 1'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          play(1'($urandom_range(1)), pick_volts(), pick_volts(), pick_volts(),
               pick_volts());
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (wave_sb.fail_count == 0 && wave_sb.pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
